### src/cn_pkg.sv
// ----------------------------------------------------------------------------
// cn_pkg: shared types and constants of the cellular noise block
// Holds the hash and generator constants, the point count thresholds, the
// controller states and the command and status structures.
// ----------------------------------------------------------------------------
package cn_pkg;

   localparam int NearestKept = 3;
   localparam int MaxPointsPerCell = 9;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_MULT = 32'd16777619;
   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [1:0] CSR_SEED = 2'd0;
   localparam logic [1:0] CSR_DIST = 2'd1;
   localparam logic [1:0] CSR_COMB = 2'd2;

   localparam logic [1:0] DIST_MANHATTAN = 2'd1;
   localparam logic [1:0] DIST_CHEBYSHEV = 2'd2;
   localparam logic [1:0] COMB_SECOND = 2'd1;
   localparam logic [1:0] COMB_THIRD = 2'd2;

   typedef logic [31:0] limit_array_type [8];
   localparam limit_array_type COUNT_LIMITS = '{
      32'd393325350, 32'd1022645910, 32'd1861739990, 32'd2700834071,
      32'd3372109335, 32'd3819626178, 32'd4075350088, 32'd4203212043};

   typedef enum logic [3:0] {
      ST_IDLE, ST_HASH_X, ST_HASH_Y, ST_HASH_Z, ST_COUNT,
      ST_OFF_X, ST_OFF_Y, ST_OFF_Z, ST_DIST, ST_KEEP, ST_NEXT, ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic hash_x;
      logic hash_y;
      logic hash_z;
      logic count;
      logic off_x;
      logic off_y;
      logic off_z;
      logic measure;
      logic keep;
      logic next_cell;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_point;
      logic last_cell;
   } status_type;

   function automatic logic [3:0] point_count(input logic [31:0] v);
      logic [3:0] n;
      n = 4'd1;
      for (int t = 0; t < 8; t++) begin
         if (v >= COUNT_LIMITS[t]) begin
            n = n + 4'd1;
         end
      end
      if (n > 4'(MaxPointsPerCell)) begin
         n = 4'(MaxPointsPerCell);
      end
      return n;
   endfunction

endpackage

### src/cellular_noise_f1.sv
// ----------------------------------------------------------------------------
// cellular_noise_f1: three-dimensional cellular noise, nearest distances
// Visits the 27 cells around the point and combines the nearest distances.
//
// channel   direction  signals
// req       in         req_valid, req_ready, req_point_x/y/z
// rsp       out        rsp_valid, rsp_ready, rsp_noise_value
// csr       in         csr_valid, csr_ready, csr_index, csr_data
//
// A request is worked by the step sequencer that walks cells and feature points,
// 27 to 243 points in all: it hashes each cell and draws its point count, then
// generates, measures and keeps each point before the response is shown.
// Reset restores the seed and mode registers and idles the controller.
// A stalled response holds the block; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module cellular_noise_f1 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [16:0]        rsp_noise_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [31:0] seed_ff;
   logic [1:0]  dist_mode_ff, comb_mode_ff;
   cn_pkg::cmd_type    cmd;
   cn_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd3221;
         dist_mode_ff <= 2'd0;
         comb_mode_ff <= 2'd0;
      end else if (csr_valid) begin
         case (csr_index)
            cn_pkg::CSR_SEED: seed_ff <= csr_data;
            cn_pkg::CSR_DIST: dist_mode_ff <= csr_data[1:0];
            cn_pkg::CSR_COMB: comb_mode_ff <= csr_data[1:0];
            default: seed_ff <= seed_ff;
         endcase
      end
   end

   cn_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd));

   cn_datapath u_dp (
      .clock(clock), .cmd(cmd), .status(status), .seed(seed_ff),
      .distance_mode(dist_mode_ff), .combine_mode(comb_mode_ff),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .rsp_noise_value(rsp_noise_value));

endmodule

### src/cn_ctrl.sv
// ----------------------------------------------------------------------------
// cn_ctrl: controller of the cellular noise block
// Sequences hashing, point generation, distance and selection per cell.
// ----------------------------------------------------------------------------
module cn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cn_pkg::status_type status,
   output cn_pkg::cmd_type    cmd
);

   cn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cn_pkg::ST_IDLE: if (req_valid) state_in = cn_pkg::ST_HASH_X;
         cn_pkg::ST_HASH_X: state_in = cn_pkg::ST_HASH_Y;
         cn_pkg::ST_HASH_Y: state_in = cn_pkg::ST_HASH_Z;
         cn_pkg::ST_HASH_Z: state_in = cn_pkg::ST_COUNT;
         cn_pkg::ST_COUNT: state_in = cn_pkg::ST_OFF_X;
         cn_pkg::ST_OFF_X: state_in = cn_pkg::ST_OFF_Y;
         cn_pkg::ST_OFF_Y: state_in = cn_pkg::ST_OFF_Z;
         cn_pkg::ST_OFF_Z: state_in = cn_pkg::ST_DIST;
         cn_pkg::ST_DIST: state_in = cn_pkg::ST_KEEP;
         cn_pkg::ST_KEEP: begin
            if (!status.last_point) state_in = cn_pkg::ST_OFF_X;
            else if (status.last_cell) state_in = cn_pkg::ST_DONE;
            else state_in = cn_pkg::ST_NEXT;
         end
         cn_pkg::ST_NEXT: state_in = cn_pkg::ST_HASH_X;
         cn_pkg::ST_DONE: if (rsp_ready) state_in = cn_pkg::ST_IDLE;
         default: state_in = cn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         cn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         cn_pkg::ST_HASH_X: cmd.hash_x = 1'b1;
         cn_pkg::ST_HASH_Y: cmd.hash_y = 1'b1;
         cn_pkg::ST_HASH_Z: cmd.hash_z = 1'b1;
         cn_pkg::ST_COUNT: cmd.count = 1'b1;
         cn_pkg::ST_OFF_X: cmd.off_x = 1'b1;
         cn_pkg::ST_OFF_Y: cmd.off_y = 1'b1;
         cn_pkg::ST_OFF_Z: cmd.off_z = 1'b1;
         cn_pkg::ST_DIST: cmd.measure = 1'b1;
         cn_pkg::ST_KEEP: begin
            cmd.keep = 1'b1;
            cmd.finish = status.last_point && status.last_cell;
         end
         cn_pkg::ST_NEXT: cmd.next_cell = 1'b1;
         cn_pkg::ST_DONE: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while a result waits");

endmodule

### src/cn_datapath.sv
// ----------------------------------------------------------------------------
// cn_datapath: datapath of the cellular noise block
// Holds the point, cell counters, hash and generator, distance and the kept
// nearest distances, with one squaring multiplier shared across the three axes.
// ----------------------------------------------------------------------------
module cn_datapath (
   input  logic               clock,
   input  cn_pkg::cmd_type    cmd,
   output cn_pkg::status_type status,
   input  logic [31:0]        seed,
   input  logic [1:0]         distance_mode,
   input  logic [1:0]         combine_mode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic [16:0]        rsp_noise_value
);

   logic [15:0] cx_ff, cy_ff, cz_ff, fx_ff, fy_ff, fz_ff;
   logic [1:0]  i_ff, j_ff, k_ff;
   logic [31:0] r_ff;
   logic [3:0]  n_ff, p_ff;
   logic signed [18:0] dx_ff, dy_ff, dz_ff;
   logic [37:0] d_ff;
   logic [37:0] dist_ff [cn_pkg::NearestKept];
   logic [16:0] res_ff;
   logic [37:0] sq_ff;

   logic [31:0] lcg;
   logic [31:0] hx, hy, hz;
   logic signed [18:0] off_d;
   logic [18:0] ax, ay, az;
   logic [37:0] sq;
   logic [37:0] d_new;

   assign lcg = r_ff * cn_pkg::LCG_MUL + cn_pkg::LCG_ADD;
   assign hx = 32'(signed'(cx_ff)) + 32'(i_ff) - 32'd1 + seed;
   assign hy = 32'(signed'(cy_ff)) + 32'(j_ff) - 32'd1;
   assign hz = 32'(signed'(cz_ff)) + 32'(k_ff) - 32'd1;

   assign ax = dx_ff[18] ? 19'(-dx_ff) : 19'(dx_ff);
   assign ay = dy_ff[18] ? 19'(-dy_ff) : 19'(dy_ff);
   assign az = dz_ff[18] ? 19'(-dz_ff) : 19'(dz_ff);

   // Each axis is squared in the step after its difference is formed, so the
   // squared distance is complete in the distance step.
   always_comb begin
      logic [18:0] m;
      m = cmd.off_y ? ax : cmd.off_z ? ay : az;
      sq = 38'(m) * 38'(m);
   end

   always_comb begin
      logic [18:0] mx;
      mx = ax;
      if (ay > mx) mx = ay;
      if (az > mx) mx = az;
      if (distance_mode == cn_pkg::DIST_MANHATTAN) begin
         d_new = 38'(ax) + 38'(ay) + 38'(az);
      end else if (distance_mode == cn_pkg::DIST_CHEBYSHEV) begin
         d_new = 38'(mx);
      end else begin
         d_new = 38'((sq_ff + sq) >> 16);
      end
   end

   always_comb begin
      logic [1:0]  ix;
      logic [15:0] f;
      ix = cmd.off_x ? i_ff : cmd.off_y ? j_ff : k_ff;
      f = cmd.off_x ? fx_ff : cmd.off_y ? fy_ff : fz_ff;
      off_d = signed'({3'b000, f}) + 19'sd65536 - signed'({1'b0, ix, 16'h0000})
              - signed'({3'b000, lcg[31:16]});
   end

   assign status.last_point = (p_ff == n_ff);
   assign status.last_cell = (i_ff == 2'd2) && (j_ff == 2'd2) && (k_ff == 2'd2);
   assign rsp_noise_value = res_ff;

   function automatic logic [16:0] combine(input logic [37:0] last);
      logic [37:0] k [cn_pkg::NearestKept];
      logic [37:0] v;
      int sel;
      for (int t = 0; t < cn_pkg::NearestKept; t++) k[t] = dist_ff[t];
      for (int t = cn_pkg::NearestKept - 1; t >= 0; t--) begin
         if (last < k[t] && (t == 0 || k[t - 1] <= last)) begin
            for (int u = cn_pkg::NearestKept - 1; u > t; u--) k[u] = k[u - 1];
            k[t] = last;
         end
      end
      sel = (combine_mode == cn_pkg::COMB_SECOND) ? 1 :
            (combine_mode == cn_pkg::COMB_THIRD) ? 2 : 0;
      if (sel > cn_pkg::NearestKept - 1) sel = cn_pkg::NearestKept - 1;
      v = (sel == 0) ? k[0] : k[sel] - k[0];
      return (v > 38'(cn_pkg::ONE_Q16)) ? cn_pkg::ONE_Q16 : v[16:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= req_point_x[31:16];
         cy_ff <= req_point_y[31:16];
         cz_ff <= req_point_z[31:16];
         fx_ff <= req_point_x[15:0];
         fy_ff <= req_point_y[15:0];
         fz_ff <= req_point_z[15:0];
         i_ff <= 2'd0;
         j_ff <= 2'd0;
         k_ff <= 2'd0;
         r_ff <= cn_pkg::FNV_BASIS;
         for (int t = 0; t < cn_pkg::NearestKept; t++) dist_ff[t] <= '1;
      end
      if (cmd.hash_x) r_ff <= (r_ff ^ hx) * cn_pkg::FNV_MULT;
      if (cmd.hash_y) r_ff <= (r_ff ^ hy) * cn_pkg::FNV_MULT;
      if (cmd.hash_z) r_ff <= (r_ff ^ hz) * cn_pkg::FNV_MULT;
      if (cmd.count) begin
         r_ff <= lcg;
         n_ff <= cn_pkg::point_count(lcg);
         p_ff <= 4'd0;
      end
      if (cmd.off_x) begin
         r_ff <= lcg;
         dx_ff <= off_d;
         p_ff <= p_ff + 4'd1;
      end
      if (cmd.off_y) begin
         r_ff <= lcg;
         dy_ff <= off_d;
         sq_ff <= sq;
      end
      if (cmd.off_z) begin
         r_ff <= lcg;
         dz_ff <= off_d;
         sq_ff <= sq_ff + sq;
      end
      if (cmd.measure) begin
         d_ff <= d_new;
      end
      if (cmd.keep) begin
         if (d_ff < dist_ff[0]) dist_ff[0] <= d_ff;
         for (int t = 1; t < cn_pkg::NearestKept; t++) begin
            if (d_ff < dist_ff[t]) begin
               dist_ff[t] <= (dist_ff[t - 1] > d_ff) ? dist_ff[t - 1] : d_ff;
            end
         end
      end
      if (cmd.next_cell) begin
         r_ff <= cn_pkg::FNV_BASIS;
         if (k_ff != 2'd2) begin
            k_ff <= k_ff + 2'd1;
         end else begin
            k_ff <= 2'd0;
            if (j_ff != 2'd2) begin
               j_ff <= j_ff + 2'd1;
            end else begin
               j_ff <= 2'd0;
               i_ff <= i_ff + 2'd1;
            end
         end
      end
      if (cmd.finish) begin
         res_ff <= combine(d_ff);
      end
   end

endmodule

### verif/tb_cellular_noise_f1.sv
// ----------------------------------------------------------------------------
// tb_cellular_noise_f1: self-checking testbench of the cellular noise block
// A directed table covers coordinate extremes, every distance and combine
// mode and the seed extremes, then random requests run under changing
// settings and three idling patterns. Every response is compared with a
// noise value worked out independently from the point and the registers.
// ----------------------------------------------------------------------------
module tb_cellular_noise_f1;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;
   localparam int HoldCycles = 3000;

   typedef struct {
      logic [31:0] seed;
      logic [1:0]  dist_mode;
      logic [1:0]  comb_mode;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [16:0]        rsp_noise_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = cn_pkg::CSR_SEED;
   logic [31:0]        csr_data = '0;

   logic [31:0] cur_seed = 32'd3221;
   logic [1:0]  cur_dist = 2'd0;
   logic [1:0]  cur_comb = 2'd0;

   logic [16:0] noise_pending [$];
   int mismatches = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_go = 1'b0;
   int quiet_cycles = 0;

   cellular_noise_f1 dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [16:0] predict_noise(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
      longint unsigned nearest [3];
      longint unsigned ax, ay, az, d, diff;
      longint fx, fy, fz, dx, dy, dz;
      int cx, cy, cz, n, sel;
      logic [31:0] r, cx_word;
      nearest = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                  64'hffff_ffff_ffff_ffff};
      cx = int'(signed'(px[31:16]));
      cy = int'(signed'(py[31:16]));
      cz = int'(signed'(pz[31:16]));
      fx = longint'(px[15:0]);
      fy = longint'(py[15:0]);
      fz = longint'(pz[15:0]);
      for (int i = -1; i <= 1; i++) begin
         for (int j = -1; j <= 1; j++) begin
            for (int k = -1; k <= 1; k++) begin
               cx_word = 32'(cx + i) + cur_seed;
               r = cn_pkg::FNV_BASIS;
               r = (r ^ cx_word) * cn_pkg::FNV_MULT;
               r = (r ^ 32'(cy + j)) * cn_pkg::FNV_MULT;
               r = (r ^ 32'(cz + k)) * cn_pkg::FNV_MULT;
               r = r * cn_pkg::LCG_MUL + cn_pkg::LCG_ADD;
               n = 1;
               for (int t = 0; t < 8; t++) begin
                  if (r >= cn_pkg::COUNT_LIMITS[t]) n++;
               end
               if (n > cn_pkg::MaxPointsPerCell) n = cn_pkg::MaxPointsPerCell;
               for (int p = 0; p < n; p++) begin
                  r = r * cn_pkg::LCG_MUL + cn_pkg::LCG_ADD;
                  dx = fx - longint'(i) * 65536 - longint'(r[31:16]);
                  r = r * cn_pkg::LCG_MUL + cn_pkg::LCG_ADD;
                  dy = fy - longint'(j) * 65536 - longint'(r[31:16]);
                  r = r * cn_pkg::LCG_MUL + cn_pkg::LCG_ADD;
                  dz = fz - longint'(k) * 65536 - longint'(r[31:16]);
                  ax = (dx < 0) ? -dx : dx;
                  ay = (dy < 0) ? -dy : dy;
                  az = (dz < 0) ? -dz : dz;
                  if (cur_dist == cn_pkg::DIST_MANHATTAN) begin
                     d = ax + ay + az;
                  end else if (cur_dist == cn_pkg::DIST_CHEBYSHEV) begin
                     d = ax;
                     if (ay > d) d = ay;
                     if (az > d) d = az;
                  end else begin
                     d = (ax * ax + ay * ay + az * az) >> 16;
                  end
                  if (d < nearest[2]) begin
                     if (d < nearest[0]) begin
                        nearest[2] = nearest[1];
                        nearest[1] = nearest[0];
                        nearest[0] = d;
                     end else if (d < nearest[1]) begin
                        nearest[2] = nearest[1];
                        nearest[1] = d;
                     end else begin
                        nearest[2] = d;
                     end
                  end
               end
            end
         end
      end
      sel = (cur_comb == cn_pkg::COMB_SECOND) ? 1 : (cur_comb == cn_pkg::COMB_THIRD) ? 2 : 0;
      if (sel > cn_pkg::NearestKept - 1) sel = cn_pkg::NearestKept - 1;
      diff = (sel == 0) ? nearest[0] : nearest[sel] - nearest[0];
      return (diff > 65536) ? cn_pkg::ONE_Q16 : 17'(diff);
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch on response %0d: %s", responses_seen, msg);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            noise_pending.push_back(predict_noise(req_point_x, req_point_y, req_point_z));
            requests_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_pending.size() == 0) begin
               report_mismatch($sformatf("noise_value 0x%05h with nothing outstanding",
                                         rsp_noise_value));
            end else if (noise_pending[0] !== rsp_noise_value) begin
               report_mismatch($sformatf("noise_value 0x%05h, expected 0x%05h",
                                         rsp_noise_value, noise_pending.pop_front()));
            end else begin
               void'(noise_pending.pop_front());
            end
            responses_seen++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WatchdogLimit) begin
            $display("FAIL cellular_noise_f1");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         hold_go <= 1'b0;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] seed, logic [1:0] dmode, logic [1:0] cmode);
      req_valid <= 1'b0;
      @(posedge clock);
      while (noise_pending.size() != 0) @(posedge clock);
      csr_write(cn_pkg::CSR_SEED, seed);
      csr_write(cn_pkg::CSR_DIST, {30'($urandom), dmode});
      csr_write(cn_pkg::CSR_COMB, {30'($urandom), cmode});
      csr_valid <= 1'b0;
      cur_seed = seed;
      cur_dist = dmode;
      cur_comb = cmode;
   endtask

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {{15{$urandom_range(1) == 1}}, 17'($urandom)};
         2: return {16'($urandom_range(3) - 1), 16'($urandom)};
         default: return {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom)};
      endcase
   endfunction

   stim_row_type directed [] = '{
      '{32'd3221, 2'd0, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'd3221, 2'd0, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
      '{32'd3221, 2'd0, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      '{32'd3221, 2'd0, 2'd0, 32'hffff_ffff, 32'h0000_ffff, 32'h0001_0000},
      '{32'd3221, 2'd0, 2'd1, 32'h0003_8000, 32'hfffe_4000, 32'h0000_0000},
      '{32'd3221, 2'd0, 2'd2, 32'h0003_8000, 32'hfffe_4000, 32'h0000_0000},
      '{32'd3221, 2'd0, 2'd3, 32'h0003_8000, 32'hfffe_4000, 32'h0000_0000},
      '{32'd0, 2'd1, 2'd0, 32'h7fff_0000, 32'h8000_ffff, 32'h0000_0000},
      '{32'd0, 2'd1, 2'd1, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_f0f0},
      '{32'd0, 2'd1, 2'd2, 32'hffff_8000, 32'h7fff_ffff, 32'h8000_0001},
      '{32'hffff_ffff, 2'd2, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'hffff_ffff, 2'd2, 2'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
      '{32'hffff_ffff, 2'd2, 2'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
      '{32'hffff_ffff, 2'd3, 2'd0, 32'h0005_1111, 32'hfff0_eeee, 32'h0000_0001},
      '{32'hffff_ffff, 2'd3, 2'd2, 32'h0005_1111, 32'hfff0_eeee, 32'h0000_0001},
      '{32'h8000_0000, 2'd3, 2'd3, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_aaaa},
      '{32'h7fff_ffff, 2'd0, 2'd2, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_5555}
   };

   initial begin
      int per_phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      recv_idle_pct = 0;
      foreach (directed[i]) begin
         if (i == 0 || directed[i].seed != cur_seed || directed[i].dist_mode != cur_dist
             || directed[i].comb_mode != cur_comb) begin
            if (i == 0) begin
               cur_seed = directed[i].seed;
            end else begin
               configure(directed[i].seed, directed[i].dist_mode, directed[i].comb_mode);
            end
         end
         send_point(directed[i].x, directed[i].y, directed[i].z);
      end
      per_phase = 530;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
         for (int n = 0; n < per_phase; n++) begin
            if (n % 106 == 0) begin
               configure($urandom_range(3) == 0 ? {32{$urandom_range(1) == 1}} : $urandom,
                         2'($urandom_range(3)), 2'($urandom_range(3)));
            end
            if (phase == 2 && n == 200) hold_go = 1'b1;
            send_point(random_coord(), random_coord(), random_coord());
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (noise_pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d requests and %0d responses over three idling patterns,",
               requests_sent, responses_seen);
      $display("with every distance and combine mode and the seed extremes.");
      if (mismatches == 0) begin
         $display("PASS cellular_noise_f1");
      end else begin
         $display("FAIL cellular_noise_f1");
      end
      $finish;
   end

endmodule
